// ===== src/icd_pkg.sv =====
// ----------------------------------------------------------------------------
// icd_pkg
// Shared types and codes for the indexed circular deque.
// ----------------------------------------------------------------------------
package icd_pkg;

  typedef enum logic [2:0] {
    FN_READ       = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_PUSH_FRONT = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_POP_FRONT  = 3'd4,
    FN_INSERT     = 3'd5,
    FN_ERASE      = 3'd6,
    FN_CLEAR      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 4;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture request, evaluate checks
    logic mem_read;   // issue memory read at rd_addr
    logic mem_write;  // write memory at wr_addr
    logic step;       // advance shift cursor
    logic commit;     // update pointers and count
    logic set_result; // latch result word
  } icd_cmd_t;

  // Status back to controller
  typedef struct packed {
    logic    shift_done;
    status_t status;
    func_t   func;
  } icd_sts_t;

endpackage

// ===== src/icd_if.sv =====
// ----------------------------------------------------------------------------
// icd_req_if / icd_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface icd_req_if;
  logic                          valid;
  logic                          ready;
  logic [icd_pkg::FUNC_W-1:0]    func;
  logic [icd_pkg::INDEX_W-1:0]   index;
  logic [icd_pkg::VALUE_W-1:0]   value;
  modport source (output valid, func, index, value, input ready);
  modport sink   (input valid, func, index, value, output ready);
endinterface

interface icd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [icd_pkg::STATUS_W-1:0]  status;
  logic [icd_pkg::VALUE_W-1:0]   read_value;
  logic [icd_pkg::COUNT_W-1:0]   entry_count;
  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

// ===== src/icd_ctrl.sv =====
// ----------------------------------------------------------------------------
// icd_ctrl
// Sequencer: accept, read/shift loop, commit, hand result out.
// ----------------------------------------------------------------------------
module icd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output icd_pkg::icd_cmd_t cmd,
  input  icd_pkg::icd_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SHRD, S_SHWR, S_RDWAIT, S_DONE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.status != icd_pkg::ST_OK) begin
          state_nxt = S_DONE;
        end else begin
          case (sts.func)
            icd_pkg::FN_READ: begin
              cmd.mem_read = 1'b1;
              state_nxt    = S_RDWAIT;
            end
            icd_pkg::FN_INSERT, icd_pkg::FN_ERASE: begin
              if (sts.shift_done) begin
                cmd.mem_write = (sts.func == icd_pkg::FN_INSERT);
                state_nxt     = S_DONE;
              end else begin
                cmd.mem_read = 1'b1;
                state_nxt    = S_SHWR;
              end
            end
            icd_pkg::FN_PUSH_BACK, icd_pkg::FN_PUSH_FRONT: begin
              cmd.mem_write = 1'b1;
              state_nxt     = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SHWR: begin
        // write moved word, advance cursor
        cmd.mem_write = 1'b1;
        cmd.step      = 1'b1;
        state_nxt     = S_SHRD;
      end
      S_SHRD: begin
        if (sts.shift_done) begin
          cmd.mem_write = (sts.func == icd_pkg::FN_INSERT);
          state_nxt     = S_DONE;
        end else begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_SHWR;
        end
      end
      S_RDWAIT: state_nxt = S_DONE;
      S_DONE: begin
        cmd.commit     = 1'b1;
        cmd.set_result = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid) else $error("commit without result");

endmodule

// ===== src/icd_dp.sv =====
// ----------------------------------------------------------------------------
// icd_dp
// Datapath: slot memory, ring pointers, count, shift cursor, result.
// ----------------------------------------------------------------------------
module icd_dp #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [icd_pkg::FUNC_W-1:0]     in_func,
  input  logic [icd_pkg::INDEX_W-1:0]    in_index,
  input  logic [icd_pkg::VALUE_W-1:0]    in_value,
  input  icd_pkg::icd_cmd_t              cmd,
  output icd_pkg::icd_sts_t              sts,
  output logic [icd_pkg::STATUS_W-1:0]   out_status,
  output logic [icd_pkg::VALUE_W-1:0]    out_read_value,
  output logic [icd_pkg::COUNT_W-1:0]    out_entry_count
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH);
  localparam logic [PW-1:0] PMAX = PW'(DEPTH - 1);
  // common width for comparing the request index against the count
  localparam int unsigned XW = ((CW > icd_pkg::INDEX_W) ? CW : icd_pkg::INDEX_W) + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  logic [PW-1:0] front_r, back_r;
  logic [CW-1:0] count_r;
  icd_pkg::func_t   func_r;
  icd_pkg::status_t st_r;
  logic [CW-1:0]         idx_r, cur_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [icd_pkg::STATUS_W-1:0] res_st_r;
  logic [icd_pkg::VALUE_W-1:0]  res_val_r;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PMAX) ? '0 : p + 1'b1;
  endfunction
  function automatic logic [PW-1:0] dec(input logic [PW-1:0] p);
    return (p == '0) ? PMAX : p - 1'b1;
  endfunction

  logic [PW-1:0] phys_cur, phys_adj, phys_idx;
  logic [PW:0]   s_cur, s_idx, s_ring;
  logic [CW-1:0] idx_in;
  logic [XW-1:0] idx_x, cnt_x;
  logic          full, empty;
  icd_pkg::status_t chk;
  icd_pkg::func_t   fn_in;

  assign idx_in = CW'(in_index);
  assign idx_x  = XW'(in_index);
  assign cnt_x  = XW'(count_r);
  assign fn_in  = icd_pkg::func_t'(in_func);
  assign full   = (count_r == CW'(DEPTH - 1));
  assign empty  = (count_r == '0);

  always_comb begin
    chk = icd_pkg::ST_OK;
    case (fn_in)
      icd_pkg::FN_READ, icd_pkg::FN_ERASE:
        if (empty) chk = icd_pkg::ST_EMPTY;
        else if (idx_x >= cnt_x) chk = icd_pkg::ST_RANGE;
      icd_pkg::FN_PUSH_BACK, icd_pkg::FN_PUSH_FRONT:
        if (full) chk = icd_pkg::ST_FULL;
      icd_pkg::FN_POP_BACK, icd_pkg::FN_POP_FRONT:
        if (empty) chk = icd_pkg::ST_EMPTY;
      icd_pkg::FN_INSERT:
        if (full) chk = icd_pkg::ST_FULL;
        else if (idx_x > cnt_x) chk = icd_pkg::ST_RANGE;
      default: chk = icd_pkg::ST_OK;
    endcase
  end

  // cursor: insert walks down from count to idx, erase walks up to count-1
  assign s_cur    = {1'b0, front_r} + (PW+1)'(cur_r);
  assign phys_cur = (s_cur >= (PW+1)'(DEPTH)) ? PW'(s_cur - (PW+1)'(DEPTH)) : PW'(s_cur);
  assign phys_adj = (func_r == icd_pkg::FN_INSERT) ? dec(phys_cur) : inc(phys_cur);
  assign s_idx    = {1'b0, front_r} + (PW+1)'(idx_r);
  assign phys_idx = (s_idx >= (PW+1)'(DEPTH)) ? PW'(s_idx - (PW+1)'(DEPTH)) : PW'(s_idx);
  assign s_ring   = {1'b0, front_r} + (PW+1)'(count_r);

  always_comb begin
    sts.func   = func_r;
    sts.status = st_r;
    if (func_r == icd_pkg::FN_INSERT) sts.shift_done = (cur_r == idx_r);
    else sts.shift_done = (cur_r + 1'b1 >= count_r);
  end

  logic [PW-1:0] rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  always_comb begin
    rd_addr = (func_r == icd_pkg::FN_READ) ? phys_idx : phys_adj;
    wr_data = val_r;
    case (func_r)
      icd_pkg::FN_PUSH_BACK:  wr_addr = back_r;
      icd_pkg::FN_PUSH_FRONT: wr_addr = dec(front_r);
      icd_pkg::FN_INSERT: begin
        wr_addr = phys_cur;
        if (!sts.shift_done) wr_data = rdata_r;
      end
      default: begin
        wr_addr = phys_cur;
        wr_data = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write) mem[wr_addr] <= wr_data;
    if (cmd.mem_read)  rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= fn_in;
      st_r   <= chk;
      idx_r  <= idx_in;
      val_r  <= DATA_WIDTH'(in_value);
      cur_r  <= (fn_in == icd_pkg::FN_INSERT) ? count_r : idx_in;
    end else if (cmd.step) begin
      cur_r  <= (func_r == icd_pkg::FN_INSERT) ? cur_r - 1'b1 : cur_r + 1'b1;
    end
    if (cmd.set_result) begin
      res_st_r  <= st_r;
      res_val_r <= (func_r == icd_pkg::FN_READ && st_r == icd_pkg::ST_OK)
                   ? icd_pkg::VALUE_W'(rdata_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (cmd.commit && st_r == icd_pkg::ST_OK) begin
      case (func_r)
        icd_pkg::FN_PUSH_BACK, icd_pkg::FN_INSERT: begin
          back_r <= inc(back_r); count_r <= count_r + 1'b1;
        end
        icd_pkg::FN_PUSH_FRONT: begin
          front_r <= dec(front_r); count_r <= count_r + 1'b1;
        end
        icd_pkg::FN_POP_BACK, icd_pkg::FN_ERASE: begin
          back_r <= dec(back_r); count_r <= count_r - 1'b1;
        end
        icd_pkg::FN_POP_FRONT: begin
          front_r <= inc(front_r); count_r <= count_r - 1'b1;
        end
        icd_pkg::FN_CLEAR: begin
          front_r <= '0; back_r <= '0; count_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_status      = res_st_r;
  assign out_read_value  = res_val_r;
  assign out_entry_count = icd_pkg::COUNT_W'(count_r);

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH - 1)) else $error("count overflow");
  a_ring: assert property (@(posedge clk) disable iff (!rst_n)
    ((s_ring >= (PW+1)'(DEPTH)) ? PW'(s_ring - (PW+1)'(DEPTH)) : PW'(s_ring)) == back_r)
    else $error("ring pointers out of step");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && func_r == icd_pkg::FN_CLEAR) |=> count_r == '0) else $error("clear failed");

endmodule

// ===== src/indexed_circular_deque_top.sv =====
// ----------------------------------------------------------------------------
// indexed_circular_deque_top
// Fixed-capacity deque addressed by logical index, one request at a time.
// ----------------------------------------------------------------------------
// Each request takes one item and returns one result item. The block works on
// one item at a time through a single-port slot memory. A read that succeeds
// passes through decide, a registered memory read and the result latch;
// push, pop, clear and every refused request go from decide straight to the
// commit and result latch; insert and erase move one entry at a time (memory
// read then write), and the number of entries that shift is at most
// DEPTH-2. A result held by the receiver stalls the block for as long as it
// waits. The next item is taken in the cycle after the result has been handed
// out, so a new item is never taken before the last result has gone. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module indexed_circular_deque_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  icd_req_if.sink   in_ch,
  icd_rsp_if.source out_ch
);

  icd_pkg::icd_cmd_t cmd;
  icd_pkg::icd_sts_t sts;

  // sequencer: owns handshakes, drives commands
  icd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: memory, pointers, result registers
  icd_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_ch.func),
    .in_index        (in_ch.index),
    .in_value        (in_ch.value),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_ch.status),
    .out_read_value  (out_ch.read_value),
    .out_entry_count (out_ch.entry_count)
  );

endmodule
